@@ hw/rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue unit.
// Used by deq_cell and double_ended_queue_unit; depends on nothing else.
`default_nettype none

package deq_pkg;

   localparam int WORD_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   typedef logic signed [WORD_W-1:0] word_type;

   // request operation codes
   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD       = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         lane_start;
   } cell_ctrl_type;

   // what each cell shows its neighbors
   typedef struct packed {
      logic     occ;
      logic     tag;
      word_type data;
      word_type lane;
   } cell_link_type;

endpackage

`default_nettype wire

@@ hw/rtl/deq_cell.sv @@
// One cell of the deque chain: holds one word, its occupancy flag and one
// stage of the back-word lane. Depends on deq_pkg.
`default_nettype none

module deq_cell
   import deq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire word_type      push_value,
   input  wire cell_link_type left,
   input  wire cell_link_type right,
   output cell_link_type      link
);

   logic     occ_ff, occ_in;
   logic     tag_ff, tag_in;
   word_type data_ff, data_in;
   word_type lane_ff, lane_in;
   logic     is_last;

   // this cell holds the back word of the queue
   assign is_last = occ_ff & ~right.occ;

   // shift, insert or remove according to the broadcast command
   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      unique case (ctrl.cmd)
         CMD_HOLD: begin
         end
         CMD_PUSH_FRONT: begin
            data_in = left.data;
            occ_in  = left.occ;
         end
         CMD_PUSH_BACK: begin
            if (!occ_ff && left.occ) begin
               data_in = push_value;
               occ_in  = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            data_in = right.data;
            occ_in  = right.occ;
         end
         CMD_POP_BACK: begin
            if (is_last) begin
               occ_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // advance the back word one cell toward the front; the tag marks arrival
   assign lane_in = is_last ? data_ff : right.lane;
   assign tag_in  = ctrl.lane_start ? is_last : (tag_ff | right.tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         tag_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      lane_ff <= lane_in;
   end

   assign link.occ  = occ_ff;
   assign link.tag  = tag_ff;
   assign link.data = data_ff;
   assign link.lane = lane_ff;

endmodule

`default_nettype wire

@@ hw/rtl/double_ended_queue_unit.sv @@
// Top level of the bounded double-ended queue: a chain of deq_cell instances
// with the request decode and the response register. Depends on deq_pkg.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_op, req_push_value
//   rsp      out        rsp_valid/stall    rsp_pop_value, rsp_status
//
// For push back, push front, pop front and any failed operation, the request
// is accepted and its response is registered at the same edge. On a pop back
// the back word walks one cell per cycle down the lane to cell 0 before it is
// returned.
// Reset (synchronous) empties the queue; the words themselves are not cleared.
// req_stall is high while a pop back is in flight or a response is stalled.
`default_nettype none

module double_ended_queue_unit
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_op,
   input  wire logic signed [WORD_W-1:0] req_push_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [WORD_W-1:0]      rsp_pop_value,
   output logic [1:0]                    rsp_status
);

   cell_ctrl_type ctrl;
   cell_link_type chain [DEPTH];
   cell_link_type front_link;
   cell_link_type end_link;
   logic [DEPTH-1:0] occ_vec;

   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_pop_value_ff, rsp_pop_value_in;
   status_type rsp_status_ff, rsp_status_in;

   logic   req_accept;
   op_type op;
   logic   full;
   logic   empty;

   assign op         = op_type'(req_op);
   assign req_stall  = busy_ff | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign full       = chain[DEPTH-1].occ;
   assign empty      = ~chain[0].occ;

   // the new word enters cell 0 from the front side
   assign front_link.occ  = 1'b1;
   assign front_link.tag  = 1'b0;
   assign front_link.data = req_push_value;
   assign front_link.lane = '0;

   // nothing lies past the last cell
   assign end_link.occ  = 1'b0;
   assign end_link.tag  = 1'b0;
   assign end_link.data = '0;
   assign end_link.lane = '0;

   // build the chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type left_nb;
      cell_link_type right_nb;
      if (i == 0) begin : g_first
         assign left_nb = front_link;
      end else begin : g_mid_l
         assign left_nb = chain[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_nb = end_link;
      end else begin : g_mid_r
         assign right_nb = chain[i+1];
      end
      deq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .push_value (req_push_value),
         .left       (left_nb),
         .right      (right_nb),
         .link       (chain[i])
      );
      assign occ_vec[i] = chain[i].occ;
   end

   // decode the request, drive the chain and load the response
   always_comb begin
      ctrl.cmd         = CMD_HOLD;
      ctrl.lane_start  = 1'b0;
      busy_in          = busy_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_pop_value_in = rsp_pop_value_ff;
      rsp_status_in    = rsp_status_ff;
      if (busy_ff) begin
         if (chain[0].tag) begin
            ctrl.cmd         = CMD_POP_BACK;
            busy_in          = 1'b0;
            rsp_valid_in     = 1'b1;
            rsp_pop_value_in = chain[0].lane;
            rsp_status_in    = ST_OK;
         end
      end else if (req_accept) begin
         unique case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               rsp_valid_in     = 1'b1;
               rsp_pop_value_in = '0;
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
                  ctrl.cmd      = (op == OP_PUSH_BACK) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
               end
            end
            OP_POP_FRONT: begin
               rsp_valid_in = 1'b1;
               if (empty) begin
                  rsp_pop_value_in = '0;
                  rsp_status_in    = ST_EMPTY;
               end else begin
                  rsp_pop_value_in = chain[0].data;
                  rsp_status_in    = ST_OK;
                  ctrl.cmd         = CMD_POP_FRONT;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  rsp_valid_in     = 1'b1;
                  rsp_pop_value_in = '0;
                  rsp_status_in    = ST_EMPTY;
               end else begin
                  ctrl.lane_start = 1'b1;
                  busy_in         = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pop_value_ff <= rsp_pop_value_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTH
   // occupied cells always form one run starting at cell 0
   a_occ_packed: assert property (@(posedge clock) disable iff (reset)
      ((occ_vec & (occ_vec + 1'b1)) == '0))
      else $error("deque cells not packed toward the front");

   // a pop back in flight never coexists with a pending response
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && rsp_valid_ff))
      else $error("response pending during pop back");

   // a pop back on a non-empty queue starts the lane walk
   a_pop_back_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op == OP_POP_BACK && !empty) |=> busy_ff)
      else $error("pop back did not start");

   // a successful push adds exactly one word
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) && !full)
      |=> ($countones(occ_vec) == $countones($past(occ_vec)) + 1))
      else $error("push did not add one word");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for double_ended_queue_unit: drives push and pop requests,
// predicts every response with a queue-based model and checks it field by field.
// Depends on deq_pkg and the double_ended_queue_unit RTL.

module tb_top;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int LONG_HOLD     = 60;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      word_type   pop_value;
      status_type status;
   } deq_response_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [1:0] req_op         = OP_PUSH_BACK;
   word_type   req_push_value = '0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   word_type   rsp_pop_value;
   logic [1:0] rsp_status;

   // predicted queue contents and responses still to arrive
   word_type         held_words[$];
   deq_response_type awaited_responses[$];

   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   bit          idle_enabled = 1'b1;
   bit          hold_toggle  = 1'b0;

   double_ended_queue_unit #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

   always #6 clock = ~clock;

   // apply one request to the predicted queue and return its response
   function automatic deq_response_type deque_apply(op_type op, word_type value);
      deq_response_type r;
      r.pop_value = '0;
      r.status    = ST_OK;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (held_words.size() >= QUEUE_DEPTH)
               r.status = ST_FULL;
            else if (op == OP_PUSH_BACK)
               held_words.push_back(value);
            else
               held_words.push_front(value);
         end
         default: begin
            if (held_words.size() == 0)
               r.status = ST_EMPTY;
            else if (op == OP_POP_FRONT)
               r.pop_value = held_words.pop_front();
            else
               r.pop_value = held_words.pop_back();
         end
      endcase
      return r;
   endfunction

   // favor the corner words, otherwise any pattern
   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0: return word_type'(32'h8000_0000);
         1: return word_type'(32'h7fff_ffff);
         2: return '0;
         3: return '1;
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at cycle %0d, %s: got %h, want %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // offer one request, hold it until accepted, then maybe idle a burst
   task automatic send_request(op_type op, word_type value);
      req_valid      <= 1'b1;
      req_op         <= op;
      req_push_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_responses.push_back(deque_apply(op, value));
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // stop offering and wait until every predicted response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      wait (awaited_responses.size() == 0);
      @(posedge clock);
   endtask

   task automatic test_empty_pops();
      send_request(OP_POP_FRONT, random_word());
      send_request(OP_POP_BACK, random_word());
   endtask

   // extreme words through both ends, then out again
   task automatic test_extreme_words();
      send_request(OP_PUSH_BACK, word_type'(32'h8000_0000));
      send_request(OP_PUSH_FRONT, word_type'(32'h7fff_ffff));
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_PUSH_FRONT, '1);
      send_request(OP_POP_FRONT, random_word());
      send_request(OP_POP_BACK, random_word());
      send_request(OP_POP_FRONT, random_word());
      send_request(OP_POP_BACK, random_word());
      send_request(OP_POP_FRONT, random_word());
   endtask

   task automatic test_random_mix(int unsigned count);
      repeat (count) send_request(op_type'($urandom_range(0, 3)), random_word());
   endtask

   // fill past full, then drain past empty; both ends hit each limit every round
   task automatic test_fill_and_drain(int unsigned rounds);
      int unsigned n;
      op_type      op;
      repeat (rounds) begin
         n = $urandom_range(18, 22);
         for (int unsigned i = 0; i < n; i++) begin
            if (i == n - 1)
               op = OP_PUSH_FRONT;
            else if (i == n - 2)
               op = OP_PUSH_BACK;
            else
               op = op_type'($urandom_range(0, 1));
            send_request(op, random_word());
         end
         n = $urandom_range(18, 22);
         for (int unsigned i = 0; i < n; i++) begin
            if (i == n - 1)
               op = OP_POP_BACK;
            else if (i == n - 2)
               op = OP_POP_FRONT;
            else
               op = op_type'($urandom_range(2, 3));
            send_request(op, random_word());
         end
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_back_pressure();
      hold_toggle = ~hold_toggle;
      repeat (40) begin
         if ($urandom_range(0, 3) != 0)
            send_request(op_type'($urandom_range(0, 1)), random_word());
         else
            send_request(op_type'($urandom_range(2, 3)), random_word());
      end
      wait_for_drain();
   endtask

   // last stretch with no idling on either side
   task automatic test_steady_stream();
      idle_enabled = 1'b0;
      test_random_mix(150);
   endtask

   // receiver side: long hold on request, otherwise random stall bursts
   int unsigned stall_left = 0;
   int unsigned hold_left  = 0;
   bit          hold_seen  = 1'b0;
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_enabled && !reset && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : response_check
      deq_response_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_pop_value, '0);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_pop_value !== want.pop_value)
               report_mismatch("pop_value", rsp_pop_value, want.pop_value);
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
         end
      end
   end

   // end the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pops();
      test_extreme_words();
      wait_for_drain();
      test_random_mix(330);
      test_fill_and_drain(8);
      test_back_pressure();
      test_steady_stream();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
